// ===== hw/rtl/pgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types, opcodes and the proportional font for the glyph blitter.
// ----------------------------------------------------------------------------
package pgb_pkg;

    // Item kinds carried on the input tuser
    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_DRAW  = 2'd0;
    localparam opcode_t OP_CLEAR = 2'd1;
    localparam opcode_t OP_READ  = 2'd2;

    localparam int GLYPH_H = 8;
    localparam int GLYPH_W = 6;

    // Printable range of the font, space to tilde
    localparam logic [7:0] CHAR_FIRST = 8'h20;
    localparam logic [7:0] CHAR_LAST  = 8'h7e;

    localparam logic [2:0] SPACE_WIDTH = 3'd3;

    // Stream payload widths
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the input transaction
        logic setup;       // compute width, clip, reset glyph walk
        logic draw_wr;     // write the modified byte, advance the walk
        logic sweep_wr;    // write the fill byte at the sweep address
        logic sweep_zero;  // fill byte is zero (reset clearing pass)
        logic rd_capture;  // capture the read result
        logic out_load;    // load the output register
    } pgb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        opcode_t opcode;
        logic    draw_ok;
        logic    row_done;
        logic    last_row;
        logic    sweep_last;
    } pgb_status_t;

    // Six font columns of a glyph, first column in the top byte.
    // Bit n of a column is pixel row n.
    function automatic logic [47:0] glyph_bits(input logic [6:0] idx);
        logic [47:0] g;
        unique case (idx)
            7'd0:  g = 48'h000000000000;
            7'd1:  g = 48'h5f0000000000;
            7'd2:  g = 48'h030003000000;
            7'd3:  g = 48'h143e143e1400;
            7'd4:  g = 48'h242a7f2a1200;
            7'd5:  g = 48'h261608343200;
            7'd6:  g = 48'h020100000000;
            7'd7:  g = 48'h364956205000;
            7'd8:  g = 48'h3e4100000000;
            7'd9:  g = 48'h413e00000000;
            7'd10: g = 48'h22147f142200;
            7'd11: g = 48'h08083e080800;
            7'd12: g = 48'h804000000000;
            7'd13: g = 48'h080808080000;
            7'd14: g = 48'h400000000000;
            7'd15: g = 48'h201008040200;
            7'd16: g = 48'h3e5149453e00;
            7'd17: g = 48'h40427f404000;
            7'd18: g = 48'h426151494600;
            7'd19: g = 48'h224949493600;
            7'd20: g = 48'h1814127f1000;
            7'd21: g = 48'h274949493100;
            7'd22: g = 48'h3e4949493200;
            7'd23: g = 48'h010161190700;
            7'd24: g = 48'h364949493600;
            7'd25: g = 48'h264949493e00;
            7'd26: g = 48'h240000000000;
            7'd27: g = 48'h402400000000;
            7'd28: g = 48'h081422410000;
            7'd29: g = 48'h141414140000;
            7'd30: g = 48'h412214080000;
            7'd31: g = 48'h02b109090600;
            7'd32: g = 48'h3e4159554e00;
            7'd33: g = 48'h7e0909097e00;
            7'd34: g = 48'h7f4949493600;
            7'd35: g = 48'h3e4141412200;
            7'd36: g = 48'h7f4141413e00;
            7'd37: g = 48'h7f4949414100;
            7'd38: g = 48'h7f0909010100;
            7'd39: g = 48'h3e4141493a00;
            7'd40: g = 48'h7f0808087f00;
            7'd41: g = 48'h417f41000000;
            7'd42: g = 48'h2041413f0100;
            7'd43: g = 48'h7f0814224100;
            7'd44: g = 48'h7f4040404000;
            7'd45: g = 48'h7f0204027f00;
            7'd46: g = 48'h7f0408107f00;
            7'd47: g = 48'h3e4141413e00;
            7'd48: g = 48'h7f0909090600;
            7'd49: g = 48'h3e4151215e00;
            7'd50: g = 48'h7f0919294600;
            7'd51: g = 48'h264949493200;
            7'd52: g = 48'h01017f010100;
            7'd53: g = 48'h3f4040403f00;
            7'd54: g = 48'h1f2040201f00;
            7'd55: g = 48'h7f2010207f00;
            7'd56: g = 48'h631408146300;
            7'd57: g = 48'h030478040300;
            7'd58: g = 48'h615149454300;
            7'd59: g = 48'h7f4141000000;
            7'd60: g = 48'h020408102000;
            7'd61: g = 48'h41417f000000;
            7'd62: g = 48'h020102000000;
            7'd63: g = 48'h808080800000;
            7'd64: g = 48'h010200000000;
            7'd65: g = 48'h384424780000;
            7'd66: g = 48'h7f4444380000;
            7'd67: g = 48'h384444280000;
            7'd68: g = 48'h3844447f0000;
            7'd69: g = 48'h385454580000;
            7'd70: g = 48'h087e09010200;
            7'd71: g = 48'h98a4a4780000;
            7'd72: g = 48'h7f0404780000;
            7'd73: g = 48'h7d0000000000;
            7'd74: g = 48'h40807d000000;
            7'd75: g = 48'h7f1028440000;
            7'd76: g = 48'h7f0000000000;
            7'd77: g = 48'h7c0438047800;
            7'd78: g = 48'h7c0404780000;
            7'd79: g = 48'h384444380000;
            7'd80: g = 48'hfc2424180000;
            7'd81: g = 48'h182424f80000;
            7'd82: g = 48'h7c0804080000;
            7'd83: g = 48'h485454200000;
            7'd84: g = 48'h043e44240000;
            7'd85: g = 48'h3c40407c0000;
            7'd86: g = 48'h1c2040201c00;
            7'd87: g = 48'h3c4038403c00;
            7'd88: g = 48'h442810284400;
            7'd89: g = 48'h9ca0a07c0000;
            7'd90: g = 48'h64544c000000;
            7'd91: g = 48'h083e41000000;
            7'd92: g = 48'h7f0000000000;
            7'd93: g = 48'h413e08000000;
            7'd94: g = 48'h020102040200;
            default: g = 48'h000000000000;
        endcase
        return g;
    endfunction

endpackage

// ===== hw/rtl/pgb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/pgb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_ctrl
// Controller: sequences the clearing pass, draw, clear and read items and
// owns the stream handshakes.
// ----------------------------------------------------------------------------
module pgb_ctrl
    import pgb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output pgb_cmd_t    cmd,
    input  pgb_status_t status
);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SETUP  = 4'd2;
    localparam logic [3:0] ST_DRD    = 4'd3;
    localparam logic [3:0] ST_DWR    = 4'd4;
    localparam logic [3:0] ST_CLEAR  = 4'd5;
    localparam logic [3:0] ST_RDATA  = 4'd6;
    localparam logic [3:0] ST_FINISH = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_zero = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                unique case (status.opcode)
                    OP_DRAW:
                    begin
                        cmd.setup  = 1'b1;
                        state_next = status.draw_ok ? ST_DRD : ST_FINISH;
                    end
                    OP_CLEAR: state_next = ST_CLEAR;
                    OP_READ:  state_next = ST_RDATA;
                    default:  state_next = ST_FINISH;
                endcase
            end
            ST_DRD:
            begin
                state_next = ST_DWR;
            end
            ST_DWR:
            begin
                cmd.draw_wr = 1'b1;
                state_next  = (status.row_done && status.last_row) ? ST_FINISH : ST_DRD;
            end
            ST_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RDATA:
            begin
                cmd.rd_capture = 1'b1;
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once the transaction is taken
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/pgb_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgb_dp
// Datapath: item registers, glyph walk, byte read-modify-write, sweep
// counter, frame store and output register.
// ----------------------------------------------------------------------------
module pgb_dp
    import pgb_pkg::*;
#(
    parameter int SCREEN_COLS = 128,
    parameter int SCREEN_ROWS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgb_cmd_t              cmd,
    output pgb_status_t           status,
    input  logic [IN_USER_W-1:0]  in_user,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int LINE_BYTES  = SCREEN_COLS / 2;
    localparam int STORE_BYTES = SCREEN_ROWS * LINE_BYTES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int TEXT_ROWS   = SCREEN_ROWS / GLYPH_H;

    // Select one font column, first column at offset zero
    function automatic logic [7:0] col_bits(input logic [47:0] g, input logic [2:0] off);
        logic [7:0] c;
        unique case (off)
            3'd0:    c = g[47:40];
            3'd1:    c = g[39:32];
            3'd2:    c = g[31:24];
            3'd3:    c = g[23:16];
            3'd4:    c = g[15:8];
            3'd5:    c = g[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Input transaction fields
    logic [2:0]  in_row;
    logic [7:0]  in_col;
    logic [7:0]  in_code;
    logic [6:0]  in_gidx;

    assign in_row  = in_data[2:0];
    assign in_col  = in_data[10:3];
    assign in_code = in_data[18:11];
    assign in_gidx = (in_code >= CHAR_FIRST && in_code <= CHAR_LAST) ?
                     (in_code[6:0] - CHAR_FIRST[6:0]) : 7'd0;

    // Item registers
    opcode_t     op_reg;
    logic [2:0]  row_reg;
    logic [7:0]  col_reg;
    logic [1:0]  colour_reg;
    logic        inv_reg;
    logic [10:0] raddr_reg;
    logic [47:0] glyph_reg;
    logic        space_reg;
    logic [2:0]  adv_reg;
    logic [2:0]  span_reg;
    logic [7:0]  rdata_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    // Walk and sweep registers
    logic [2:0]        off_reg;
    logic [2:0]        off_next;
    logic [2:0]        prow_reg;
    logic [2:0]        prow_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [ADDR_W-1:0] sweep_next;

    // Range, width and clip
    logic       draw_ok;
    logic [2:0] raw_w;
    logic [9:0] right_sum;
    logic [2:0] clip_w;

    assign draw_ok = ({1'b0, row_reg} < 4'(TEXT_ROWS)) && ({1'b0, col_reg} < 9'(SCREEN_COLS));

    always_comb
    begin
        priority if (space_reg)
        begin
            raw_w = SPACE_WIDTH;
        end
        else if (glyph_reg[15:8] != 8'h00)
        begin
            raw_w = 3'd6;
        end
        else if (glyph_reg[23:16] != 8'h00)
        begin
            raw_w = 3'd5;
        end
        else if (glyph_reg[31:24] != 8'h00)
        begin
            raw_w = 3'd4;
        end
        else if (glyph_reg[39:32] != 8'h00)
        begin
            raw_w = 3'd3;
        end
        else
        begin
            raw_w = 3'd2;
        end
    end

    // Keep the last screen column free
    assign right_sum = {2'b00, col_reg} + {7'd0, raw_w} + 10'd1;
    assign clip_w    = (right_sum >= 10'(SCREEN_COLS)) ?
                       3'(9'(SCREEN_COLS - 1) - {1'b0, col_reg}) : raw_w;

    // Byte read-modify-write for the current walk position
    logic [8:0]        pos;
    logic [3:0]        off_inc;
    logic              hi_pair;
    logic [7:0]        col_a;
    logic [7:0]        col_b;
    logic              fg_a;
    logic              fg_b;
    logic              lo_en;
    logic              hi_en;
    logic              lo_fg;
    logic              hi_fg;
    logic [7:0]        cbyte;
    logic [7:0]        ibyte;
    logic [7:0]        mask;
    logic [7:0]        add_bits;
    logic [7:0]        new_byte;
    logic [3:0]        off_sum;
    logic              row_done;
    logic [5:0]        pix_row;
    logic [ADDR_W-1:0] draw_addr;
    logic [7:0]        ram_rdata;

    assign pos      = {1'b0, col_reg} + {6'd0, off_reg};
    assign off_inc  = {1'b0, off_reg} + 4'd1;
    assign hi_pair  = !pos[0] && (off_inc < {1'b0, span_reg});
    assign col_a    = col_bits(glyph_reg, off_reg);
    assign col_b    = col_bits(glyph_reg, off_inc[2:0]);
    assign fg_a     = col_a[prow_reg];
    assign fg_b     = col_b[prow_reg];
    assign lo_en    = !pos[0];
    assign hi_en    = pos[0] || hi_pair;
    assign lo_fg    = !pos[0] && fg_a;
    assign hi_fg    = pos[0] ? fg_a : (hi_pair && fg_b);
    assign cbyte    = {2'b00, colour_reg, 2'b00, colour_reg};
    assign ibyte    = inv_reg ? cbyte : 8'h00;
    assign mask     = {{4{hi_en}}, {4{lo_en}}};
    assign add_bits = cbyte & {{4{hi_fg}}, {4{lo_fg}}};
    assign new_byte = ((ibyte & mask) | (ram_rdata & ~mask)) ^ add_bits;
    assign off_sum  = hi_pair ? ({1'b0, off_reg} + 4'd2) : off_inc;
    assign row_done = off_sum >= {1'b0, span_reg};
    assign pix_row  = {row_reg, prow_reg};
    assign draw_addr = ADDR_W'(32'(pix_row) * LINE_BYTES + 32'(pos[8:1]));

    // Frame store ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              rd_in_range;
    logic              sweep_last;

    assign sweep_last  = sweep_reg == ADDR_W'(STORE_BYTES - 1);
    assign rd_in_range = 32'(raddr_reg) < STORE_BYTES;
    assign ram_we      = cmd.draw_wr || cmd.sweep_wr;
    assign ram_waddr   = cmd.sweep_wr ? sweep_reg : draw_addr;
    assign ram_wdata   = cmd.sweep_wr ? (cmd.sweep_zero ? 8'h00 : cbyte) : new_byte;
    assign ram_raddr   = (op_reg == OP_READ) ? ADDR_W'(raddr_reg) : draw_addr;

    pgb_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk and sweep next values
    always_comb
    begin
        off_next   = off_reg;
        prow_next  = prow_reg;
        sweep_next = sweep_reg;
        if (cmd.setup)
        begin
            off_next  = 3'd0;
            prow_next = 3'd0;
        end
        else if (cmd.draw_wr)
        begin
            if (row_done)
            begin
                off_next  = 3'd0;
                prow_next = prow_reg + 3'd1;
            end
            else
            begin
                off_next = off_sum[2:0];
            end
        end
        if (cmd.sweep_wr)
        begin
            sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg   <= 3'd0;
            prow_reg  <= 3'd0;
            sweep_reg <= '0;
        end
        else
        begin
            off_reg   <= off_next;
            prow_reg  <= prow_next;
            sweep_reg <= sweep_next;
        end
    end

    // Capture the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_user;
            row_reg    <= in_row;
            col_reg    <= in_col;
            colour_reg <= in_data[20:19];
            inv_reg    <= in_data[21];
            raddr_reg  <= in_data[32:22];
            glyph_reg  <= glyph_bits(in_gidx);
            space_reg  <= in_gidx == 7'd0;
        end
        if (cmd.setup)
        begin
            adv_reg  <= draw_ok ? clip_w : 3'd0;
            span_reg <= (clip_w == 3'd0) ? 3'd1 : clip_w;
        end
        if (cmd.rd_capture)
        begin
            rdata_reg <= rd_in_range ? ram_rdata : 8'h00;
        end
    end

    // Output register: next_column, advance, read_data from the low bit up
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            unique case (op_reg)
                OP_DRAW:
                begin
                    out_reg <= {5'd0, 8'h00, adv_reg, col_reg + {5'd0, adv_reg}};
                end
                OP_READ:
                begin
                    out_reg <= {5'd0, rdata_reg, 3'd0, 8'h00};
                end
                default:
                begin
                    out_reg <= '0;
                end
            endcase
        end
    end

    assign out_data = out_reg;

    assign status.opcode     = op_reg;
    assign status.draw_ok    = draw_ok;
    assign status.row_done   = row_done;
    assign status.last_row   = prow_reg == 3'(GLYPH_H - 1);
    assign status.sweep_last = sweep_last;

endmodule

// ===== hw/rtl/proportional_glyph_blitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_glyph_blitter_unit
// 4-bit-per-pixel text framebuffer with a proportional 6x8 font.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel; tuser carries the opcode (draw, clear,
//   read). Each item returns exactly one result transaction on m_axis.
//   The block works on one item at a time; s_axis_tready is high only when
//   the controller is idle.
//   Draw: a setup step, then a store read and a store write for each touched
//   byte, 1 to 4 bytes per pixel row over 8 rows; nothing is drawn when the
//   text line or the column is out of range. The store read is registered,
//   so each byte needs its own read step before its write.
//   Clear: writes one byte per cycle over all SCREEN_ROWS*SCREEN_COLS/2 bytes.
//   Read: the result comes from the registered store read.
//   Reset: the store is cleared to zero by a pass over SCREEN_ROWS*SCREEN_COLS/2
//   bytes (2048 by default) before s_axis_tready first rises.
//   Stall: the result sits in an output register; a new item is accepted
//   while it waits, and that item's result is held until the register frees.
// ----------------------------------------------------------------------------
module proportional_glyph_blitter_unit
    import pgb_pkg::*;
#(
    parameter int SCREEN_COLS = 128,
    parameter int SCREEN_ROWS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] glyph_line, [10:3] pixel_column, [18:11] char_code, [20:19] colour,
    // [21] inverse_video, [32:22] read_address, [39:33] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] opcode
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] next_column, [10:8] advance, [18:11] read_data, [23:19] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    pgb_cmd_t    cmd;
    pgb_status_t status;

    pgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    pgb_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_user  (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .out_data (m_axis_tdata)
    );

    // One item in flight: ready drops after every accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // Advance never exceeds the widest glyph
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:8] <= 3'd6)
        else $error("advance out of range");

    // A result is either a draw result or a read result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:8] == 3'd0 || m_axis_tdata[18:11] == 8'h00))
        else $error("draw and read fields both set");

endmodule

// ===== verif/proportional_glyph_blitter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proportional_glyph_blitter_unit_tb
// Self-checking bench for the glyph blitter. Drives draw, clear, read and the
// unused opcode over the s_axis channel and keeps a shadow framebuffer that
// renders each glyph the way the block should. Every m_axis transaction is
// compared field by field against the oldest predicted result. Covers font
// trimming, right-edge clipping, out-of-range rows and columns, inverse video
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module proportional_glyph_blitter_unit_tb
    import pgb_pkg::*;
();

    localparam int SCREEN_COLS  = 128;
    localparam int SCREEN_ROWS  = 32;
    localparam int LINE_BYTES   = SCREEN_COLS / 2;
    localparam int STORE_BYTES  = SCREEN_ROWS * LINE_BYTES;
    localparam int TEXT_LINES   = SCREEN_ROWS / GLYPH_H;
    localparam int TEXT_BYTES   = GLYPH_H * LINE_BYTES;
    localparam int IDLE_PCT     = 37;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 12000;
    localparam int DRAIN_CYCLES = 100;

    // Opcode that the block must ignore
    localparam opcode_t OP_UNUSED = 2'd3;

    // Input fields, glyph_line in the lowest bits
    typedef struct packed {
        logic [10:0] read_address;
        logic        inverse_video;
        logic [1:0]  colour;
        logic [7:0]  char_code;
        logic [7:0]  pixel_column;
        logic [2:0]  glyph_line;
    } blit_fields_t;

    // Result fields, next_column in the lowest bits
    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] advance;
        logic [7:0] next_column;
    } blit_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [IN_USER_W-1:0]  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [7:0]   frame_shadow [STORE_BYTES];
    blit_result_t pending_results [$];
    blit_result_t last_prediction;

    int idle_pct = IDLE_PCT;
    bit hold_request = 1'b0;
    int mismatches = 0;
    int results_checked = 0;
    int n_draw = 0;
    int n_clear = 0;
    int n_read = 0;
    int n_unused = 0;

    proportional_glyph_blitter_unit #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Generate the 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Font columns of a glyph, first column in the top byte, bit n = pixel row n
    function automatic logic [47:0] font_glyph(input int idx);
        logic [47:0] g;
        case (idx)
            0:  g = 48'h000000000000;  1: g = 48'h5f0000000000;  2: g = 48'h030003000000;
            3:  g = 48'h143e143e1400;  4: g = 48'h242a7f2a1200;  5: g = 48'h261608343200;
            6:  g = 48'h020100000000;  7: g = 48'h364956205000;  8: g = 48'h3e4100000000;
            9:  g = 48'h413e00000000; 10: g = 48'h22147f142200; 11: g = 48'h08083e080800;
            12: g = 48'h804000000000; 13: g = 48'h080808080000; 14: g = 48'h400000000000;
            15: g = 48'h201008040200; 16: g = 48'h3e5149453e00; 17: g = 48'h40427f404000;
            18: g = 48'h426151494600; 19: g = 48'h224949493600; 20: g = 48'h1814127f1000;
            21: g = 48'h274949493100; 22: g = 48'h3e4949493200; 23: g = 48'h010161190700;
            24: g = 48'h364949493600; 25: g = 48'h264949493e00; 26: g = 48'h240000000000;
            27: g = 48'h402400000000; 28: g = 48'h081422410000; 29: g = 48'h141414140000;
            30: g = 48'h412214080000; 31: g = 48'h02b109090600; 32: g = 48'h3e4159554e00;
            33: g = 48'h7e0909097e00; 34: g = 48'h7f4949493600; 35: g = 48'h3e4141412200;
            36: g = 48'h7f4141413e00; 37: g = 48'h7f4949414100; 38: g = 48'h7f0909010100;
            39: g = 48'h3e4141493a00; 40: g = 48'h7f0808087f00; 41: g = 48'h417f41000000;
            42: g = 48'h2041413f0100; 43: g = 48'h7f0814224100; 44: g = 48'h7f4040404000;
            45: g = 48'h7f0204027f00; 46: g = 48'h7f0408107f00; 47: g = 48'h3e4141413e00;
            48: g = 48'h7f0909090600; 49: g = 48'h3e4151215e00; 50: g = 48'h7f0919294600;
            51: g = 48'h264949493200; 52: g = 48'h01017f010100; 53: g = 48'h3f4040403f00;
            54: g = 48'h1f2040201f00; 55: g = 48'h7f2010207f00; 56: g = 48'h631408146300;
            57: g = 48'h030478040300; 58: g = 48'h615149454300; 59: g = 48'h7f4141000000;
            60: g = 48'h020408102000; 61: g = 48'h41417f000000; 62: g = 48'h020102000000;
            63: g = 48'h808080800000; 64: g = 48'h010200000000; 65: g = 48'h384424780000;
            66: g = 48'h7f4444380000; 67: g = 48'h384444280000; 68: g = 48'h3844447f0000;
            69: g = 48'h385454580000; 70: g = 48'h087e09010200; 71: g = 48'h98a4a4780000;
            72: g = 48'h7f0404780000; 73: g = 48'h7d0000000000; 74: g = 48'h40807d000000;
            75: g = 48'h7f1028440000; 76: g = 48'h7f0000000000; 77: g = 48'h7c0438047800;
            78: g = 48'h7c0404780000; 79: g = 48'h384444380000; 80: g = 48'hfc2424180000;
            81: g = 48'h182424f80000; 82: g = 48'h7c0804080000; 83: g = 48'h485454200000;
            84: g = 48'h043e44240000; 85: g = 48'h3c40407c0000; 86: g = 48'h1c2040201c00;
            87: g = 48'h3c4038403c00; 88: g = 48'h442810284400; 89: g = 48'h9ca0a07c0000;
            90: g = 48'h64544c000000; 91: g = 48'h083e41000000; 92: g = 48'h7f0000000000;
            93: g = 48'h413e08000000; 94: g = 48'h020102040200;
            default: g = 48'h000000000000;
        endcase
        return g;
    endfunction

    function automatic logic [7:0] font_column(input logic [47:0] g, input int k);
        return g[47 - 8 * k -: 8];
    endfunction

    // Update the shadow framebuffer and queue the result the block should return
    task automatic blit_predict(input opcode_t op, input blit_fields_t f);
        blit_result_t r;
        logic [47:0]  g;
        logic [7:0]   cbyte;
        logic [7:0]   ibyte;
        logic [7:0]   mask;
        logic [7:0]   fcol;
        logic [7:0]   add;
        int           col;
        int           code;
        int           width;
        int           off;
        int           addr;
        r = '0;
        cbyte = {2'b00, f.colour, 2'b00, f.colour};
        case (op)
            OP_DRAW:
            begin
                col = f.pixel_column;
                width = 0;
                if (f.glyph_line < TEXT_LINES && col < SCREEN_COLS)
                begin
                    code = f.char_code;
                    if (code < CHAR_FIRST || code > CHAR_LAST)
                        code = CHAR_FIRST;
                    g = font_glyph(code - CHAR_FIRST);
                    // trim trailing empty font columns, keep one spacing column
                    if (code == CHAR_FIRST)
                        width = SPACE_WIDTH;
                    else
                    begin
                        width = GLYPH_W;
                        while (width > 2 && font_column(g, width - 2) == 8'h00)
                            width--;
                    end
                    // keep the last screen column free
                    if (col + width + 1 >= SCREEN_COLS)
                        width = SCREEN_COLS - col - 1;
                    ibyte = f.inverse_video ? cbyte : 8'h00;
                    for (int prow = 0; prow < GLYPH_H; prow++)
                    begin
                        mask = col[0] ? 8'hf0 : 8'h0f;
                        off = 0;
                        // at least one column is always touched
                        do
                        begin
                            addr = (f.glyph_line * GLYPH_H + prow) * LINE_BYTES + ((col + off) >> 1);
                            fcol = font_column(g, (off < GLYPH_W) ? off : 0);
                            add = fcol[prow] ? (cbyte & mask) : 8'h00;
                            if (addr < STORE_BYTES)
                                frame_shadow[addr] =
                                    ((ibyte & mask) | (frame_shadow[addr] & ~mask)) ^ add;
                            mask = ~mask;
                            off++;
                        end while (off < width);
                    end
                end
                r.advance = 3'(width);
                r.next_column = 8'(col + width);
                n_draw++;
            end
            OP_CLEAR:
            begin
                foreach (frame_shadow[i])
                    frame_shadow[i] = cbyte;
                n_clear++;
            end
            OP_READ:
            begin
                if (f.read_address < STORE_BYTES)
                    r.read_data = frame_shadow[f.read_address];
                n_read++;
            end
            default:
                n_unused++;
        endcase
        last_prediction = r;
        pending_results.push_back(r);
    endtask

    // Offer one transaction, optionally after an idle gap; returns at the accepting edge
    task automatic send_item(input opcode_t op, input blit_fields_t f);
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, f};
        s_axis_tuser  <= op;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        blit_predict(op, f);
    endtask

    function automatic blit_fields_t random_fields();
        blit_fields_t f;
        f.glyph_line    = 3'($urandom_range(7));
        f.pixel_column  = 8'($urandom_range(255));
        f.char_code     = 8'($urandom_range(255));
        f.colour        = 2'($urandom_range(3));
        f.inverse_video = 1'($urandom_range(1));
        f.read_address  = 11'($urandom_range(STORE_BYTES - 1));
        return f;
    endfunction

    function automatic blit_fields_t draw_fields(input int row, input int col,
                                                 input int code, input int colour,
                                                 input int inv, input int addr);
        blit_fields_t f;
        f.glyph_line    = 3'(row);
        f.pixel_column  = 8'(col);
        f.char_code     = 8'(code);
        f.colour        = 2'(colour);
        f.inverse_video = 1'(inv);
        f.read_address  = 11'(addr);
        return f;
    endfunction

    // Field extremes, every opcode, trimming, clipping and range rules
    task automatic test_directed();
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, 0));
        send_item(OP_READ,   draw_fields(7, 255, 255, 3, 1, STORE_BYTES - 1));
        send_item(OP_DRAW,   draw_fields(0, 0, 8'h21, 3, 0, 0));
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, 0));
        send_item(OP_DRAW,   draw_fields(0, 2, 8'h57, 2, 1, 0));
        // odd column, descender in font bit 7
        send_item(OP_DRAW,   draw_fields(0, 9, 8'h67, 1, 1, 0));
        // codes outside the printable range fall back to space
        send_item(OP_DRAW,   draw_fields(1, 10, 8'h00, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(1, 13, 8'hff, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(1, 20, 8'h7e, 3, 0, 0));
        send_item(OP_DRAW,   draw_fields(1, 26, 8'h7f, 2, 1, 0));
        // clipped at the right edge, then the last column with zero advance
        send_item(OP_DRAW,   draw_fields(3, 124, 8'h4d, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(3, 127, 8'h23, 2, 0, 0));
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, STORE_BYTES - 1));
        // row or column out of range draws nothing
        send_item(OP_DRAW,   draw_fields(0, 128, 8'h41, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(2, 255, 8'h41, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(4, 0, 8'h41, 3, 1, 0));
        send_item(OP_DRAW,   draw_fields(7, 5, 8'h41, 3, 1, 0));
        send_item(OP_UNUSED, random_fields());
        send_item(OP_DRAW,   draw_fields(2, 0, 8'h20, 2, 1, 0));
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, 2 * TEXT_BYTES));
        send_item(OP_CLEAR,  draw_fields(0, 0, 0, 1, 0, 0));
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, 1000));
        send_item(OP_DRAW,   draw_fields(2, 40, 8'h41, 1, 0, 0));
        send_item(OP_READ,   draw_fields(0, 0, 0, 0, 0, 2 * TEXT_BYTES + 20));
        send_item(OP_CLEAR,  draw_fields(0, 0, 0, 0, 0, 0));
    endtask

    // Lines of text flowing across the screen, read-backs of the line being
    // written, occasional clears and noise items with arbitrary fields
    task automatic test_text_traffic(input int n_items);
        blit_fields_t f;
        opcode_t      op;
        int           pick;
        int           cursor;
        int           line;
        cursor = $urandom_range(6);
        line = $urandom_range(TEXT_LINES - 1);
        repeat (n_items)
        begin
            f = random_fields();
            pick = $urandom_range(99);
            if (pick < 58)
            begin
                op = OP_DRAW;
                f.glyph_line = 3'(line);
                f.pixel_column = 8'(cursor);
                if ($urandom_range(9) != 0)
                    f.char_code = 8'($urandom_range(CHAR_LAST, CHAR_FIRST));
            end
            else if (pick < 88)
            begin
                op = OP_READ;
                if ($urandom_range(3) != 0)
                    f.read_address = 11'(line * TEXT_BYTES + $urandom_range(TEXT_BYTES - 1));
            end
            else if (pick < 91)
                op = OP_CLEAR;
            else if (pick < 94)
                op = OP_UNUSED;
            else
                op = OP_DRAW;
            send_item(op, f);
            // follow the text cursor; wrap once the last column is reached
            if (pick < 58)
            begin
                cursor = last_prediction.next_column;
                if (last_prediction.advance == 3'd0)
                begin
                    cursor = $urandom_range(6);
                    line = (line + 1) % TEXT_LINES;
                end
            end
            if ($urandom_range(49) == 0)
                line = $urandom_range(TEXT_LINES - 1);
        end
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_steady_stream(input int n_items);
        idle_pct = 0;
        test_text_traffic(n_items);
        idle_pct = IDLE_PCT;
    endtask

    // Hold the output off while items keep coming so the input stalls
    task automatic test_output_backpressure();
        idle_pct = 0;
        hold_request = 1'b1;
        test_text_traffic(10);
        idle_pct = IDLE_PCT;
    endtask

    // Drive the result ready, with random stalls and one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(negedge clk)
    begin : check_result
        blit_result_t exp_r;
        blit_result_t got_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_r = m_axis_tdata[$bits(blit_result_t)-1:0];
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                results_checked++;
                if (got_r.next_column !== exp_r.next_column)
                begin
                    $error("next_column: expected %0d, got %0d",
                           exp_r.next_column, got_r.next_column);
                    mismatches++;
                end
                if (got_r.advance !== exp_r.advance)
                begin
                    $error("advance: expected %0d, got %0d", exp_r.advance, got_r.advance);
                    mismatches++;
                end
                if (got_r.read_data !== exp_r.read_data)
                begin
                    $error("read_data: expected %h, got %h", exp_r.read_data, got_r.read_data);
                    mismatches++;
                end
            end
        end
    end

    // End the run when no transaction moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles, %0d results pending",
                 QUIET_LIMIT, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    // Reset, run the tests in turn, drain and report
    initial
    begin
        foreach (frame_shadow[i])
            frame_shadow[i] = 8'h00;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_DRAW;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_text_traffic(650);
        test_steady_stream(150);
        test_output_backpressure();
        test_text_traffic(90);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d draws, %0d clears, %0d reads and %0d unused opcodes;",
                 n_draw, n_clear, n_read, n_unused);
        $display("%0d results compared, %0d field mismatches.", results_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
